// ===== rtl/core/zph_pkg.sv =====
// Package for the Zobrist position hash: item codes, key-table layout and
// the splitmix64 key generator, which is only evaluated on constant indices.
// No dependencies.
package zph_pkg;

  typedef logic [63:0] key_t;

  typedef enum logic {
    CMD_BOARD  = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_t;

  localparam int unsigned SQUARES     = 64;
  localparam int unsigned KEYS_PER_SQ = 12;
  localparam int unsigned CASTLE_BASE = 768;
  localparam int unsigned CASTLE_KEYS = 16;
  localparam int unsigned EP_BASE     = 784;
  localparam int unsigned EP_KEYS     = 8;
  localparam int unsigned SIDE_INDEX  = 792;

  localparam logic [2:0] PIECE_MAX   = 3'd5;
  localparam logic [3:0] BLACK_OFFS  = 4'd6;

  localparam key_t KEY_SEED  = 64'd20250601;
  localparam key_t GAMMA     = 64'h9e3779b97f4a7c15;
  localparam key_t MIX_MUL_A = 64'hbf58476d1ce4e5b9;
  localparam key_t MIX_MUL_B = 64'h94d049bb133111eb;

  typedef logic [KEYS_PER_SQ-1:0][63:0] sq_row_t;
  typedef logic [CASTLE_KEYS-1:0][63:0] castle_row_t;
  typedef logic [EP_KEYS-1:0][63:0]     ep_row_t;

  // Output idx of splitmix64: state after idx+1 steps is seed + (idx+1)*gamma.
  function automatic key_t key_at(input int unsigned idx);
    key_t z;
    z = KEY_SEED + (64'(idx) + 64'd1) * GAMMA;
    z = (z ^ (z >> 30)) * MIX_MUL_A;
    z = (z ^ (z >> 27)) * MIX_MUL_B;
    return z ^ (z >> 31);
  endfunction

  function automatic sq_row_t square_row(input int unsigned sq);
    sq_row_t row;
    for (int unsigned i = 0; i < KEYS_PER_SQ; i++) begin
      row[i] = key_at(sq * KEYS_PER_SQ + i);
    end
    return row;
  endfunction

  function automatic castle_row_t castle_row();
    castle_row_t row;
    for (int unsigned i = 0; i < CASTLE_KEYS; i++) begin
      row[i] = key_at(CASTLE_BASE + i);
    end
    return row;
  endfunction

  function automatic ep_row_t ep_row();
    ep_row_t row;
    for (int unsigned i = 0; i < EP_KEYS; i++) begin
      row[i] = key_at(EP_BASE + i);
    end
    return row;
  endfunction

endpackage

// ===== rtl/core/zph_lanes.sv =====
// Square lanes: each lane picks its constant key for the bitboard's color and
// piece, masked by occupancy; a 64-leaf XOR tree folds the lanes. Uses zph_pkg.
module zph_lanes (
  input  logic        color,
  input  logic [2:0]  piece,
  input  logic [63:0] occupancy,
  output zph_pkg::key_t board_key
);
  import zph_pkg::*;

  localparam int unsigned NODES = 2 * SQUARES - 1;

  logic        piece_ok;
  logic [3:0]  code;
  logic [63:0] occ_m;
  key_t        node [NODES];

  assign piece_ok = (piece <= PIECE_MAX);
  // Drop the whole bitboard for piece codes six and seven.
  assign code  = !piece_ok ? 4'd0 : (color ? ({1'b0, piece} + BLACK_OFFS) : {1'b0, piece});
  assign occ_m = piece_ok ? occupancy : '0;

  for (genvar s = 0; s < SQUARES; s++) begin : g_lane
    localparam sq_row_t ROW = square_row(s);
    assign node[SQUARES - 1 + s] = occ_m[s] ? ROW[code] : '0;
  end

  for (genvar n = 0; n < SQUARES - 1; n++) begin : g_tree
    assign node[n] = node[2 * n + 1] ^ node[2 * n + 2];
  end

  assign board_key = node[0];

endmodule

// ===== rtl/core/zph_flags.sv =====
// Position flag keys: castling, en-passant file and side to move, folded into
// one 64-bit word. Uses zph_pkg.
module zph_flags (
  input  logic        [3:0] castle,
  input  logic              ep_valid,
  input  logic        [2:0] ep_file,
  input  logic              black_to_move,
  output zph_pkg::key_t     flag_key
);
  import zph_pkg::*;

  localparam castle_row_t CASTLE_ROW = castle_row();
  localparam ep_row_t     EP_ROW     = ep_row();
  localparam key_t        SIDE_KEY   = key_at(SIDE_INDEX);

  key_t ep_key;
  key_t side_key;

  assign ep_key   = ep_valid ? EP_ROW[ep_file] : '0;
  assign side_key = black_to_move ? SIDE_KEY : '0;
  assign flag_key = CASTLE_ROW[castle] ^ ep_key ^ side_key;

endmodule

// ===== rtl/core/zobrist_position_hash_top.sv =====
// Zobrist position hash, top level.
// Depends on zph_pkg, zph_lanes and zph_flags.
//
// Usage: present a position as any number of piece bitboard requests
// (in_command = 0, with in_color, in_piece, in_occupancy) followed by one
// finish request (in_command = 1, with in_castle, in_ep_valid, in_ep_file,
// in_black_to_move). Bitboard requests produce no result; each finish request
// produces one out_hash and clears the running hash for the next position.
// Both channels use valid/stall; a request moves when valid is high and stall
// is low. Piece codes six and seven leave the running hash unchanged.
//
// Timing: a request is captured into an input register, then one pass of
// lane select plus a six-level XOR tree updates the running hash or loads
// the result register. Throughput is one request per cycle while in_stall
// is low. All keys are elaboration-time constants: no table fill is needed
// after reset.
// Reset (rst_n low, synchronous) empties both registers and zeros the hash.
// While out_stall holds a result, bitboard requests keep flowing; a second
// finish waits in the input register and in_stall rises until the result
// is taken.
module zobrist_position_hash_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_command,
  input  logic          in_color,
  input  logic [2:0]    in_piece,
  input  logic [63:0]   in_occupancy,
  input  logic [3:0]    in_castle,
  input  logic          in_ep_valid,
  input  logic [2:0]    in_ep_file,
  input  logic          in_black_to_move,
  output logic          out_valid,
  input  logic          out_stall,
  output zph_pkg::key_t out_hash
);
  import zph_pkg::*;

  // Input register
  logic        s1_vld_r, s1_vld_nxt;
  cmd_t        s1_cmd_r;
  logic        s1_color_r;
  logic [2:0]  s1_piece_r;
  logic [63:0] s1_occ_r;
  logic [3:0]  s1_castle_r;
  logic        s1_ep_valid_r;
  logic [2:0]  s1_ep_file_r;
  logic        s1_btm_r;

  // Accumulator and result register
  key_t        running_hash_r, running_hash_nxt;
  logic        out_valid_r, out_valid_nxt;
  key_t        out_hash_r;

  logic        in_accept;
  logic        s1_adv;
  logic        out_load;
  key_t        board_key;
  key_t        flag_key;

  // Advance the input register: bitboards always leave, a finish needs the
  // result register free or being emptied this cycle.
  assign s1_adv    = s1_vld_r && ((s1_cmd_r == CMD_BOARD) || !out_valid_r || !out_stall);
  assign out_load  = s1_adv && (s1_cmd_r == CMD_FINISH);
  assign in_stall  = s1_vld_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  zph_lanes u_lanes (
    .color     (s1_color_r),
    .piece     (s1_piece_r),
    .occupancy (s1_occ_r),
    .board_key (board_key)
  );

  zph_flags u_flags (
    .castle        (s1_castle_r),
    .ep_valid      (s1_ep_valid_r),
    .ep_file       (s1_ep_file_r),
    .black_to_move (s1_btm_r),
    .flag_key      (flag_key)
  );

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_accept) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    running_hash_nxt = running_hash_r;
    if (s1_adv) begin
      // Clear on finish, fold the bitboard otherwise.
      running_hash_nxt = (s1_cmd_r == CMD_FINISH) ? '0 : (running_hash_r ^ board_key);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r       <= 1'b0;
      out_valid_r    <= 1'b0;
      running_hash_r <= '0;
    end else begin
      s1_vld_r       <= s1_vld_nxt;
      out_valid_r    <= out_valid_nxt;
      running_hash_r <= running_hash_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd_r      <= cmd_t'(in_command);
      s1_color_r    <= in_color;
      s1_piece_r    <= in_piece;
      s1_occ_r      <= in_occupancy;
      s1_castle_r   <= in_castle;
      s1_ep_valid_r <= in_ep_valid;
      s1_ep_file_r  <= in_ep_file;
      s1_btm_r      <= in_black_to_move;
    end
    if (out_load) begin
      out_hash_r <= running_hash_r ^ flag_key;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hash  = out_hash_r;

  // A finish leaving the input register clears the accumulator.
  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_cmd_r == CMD_FINISH)) |=> (running_hash_r == '0))
    else $error("running hash not cleared after finish");

  // Invalid piece codes leave the accumulator alone.
  a_bad_piece_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_cmd_r == CMD_BOARD) && (s1_piece_r > PIECE_MAX))
      |=> $stable(running_hash_r))
    else $error("invalid piece code changed running hash");

  // Stall only while an item sits in the input register.
  a_stall_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_vld_r)
    else $error("input stalled with empty input register");

  // A held result is never overwritten by a new finish.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !out_load)
    else $error("result register overwritten while stalled");

endmodule
